// File: hw/rtl/rx_ring_header_reader_macros.svh
// assertion macros for the receive ring header reader
// used by the top level; no other dependencies
`ifndef RX_RING_HEADER_READER_MACROS_SVH
`define RX_RING_HEADER_READER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, held off during reset
`define RXHR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rxhr assertion failed");

// next-cycle implication, held off during reset
`define RXHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rxhr assertion failed");

`else

`define RXHR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RXHR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/rxhr_pkg.sv
// shared types and constants for the receive ring header reader
// no dependencies
package rxhr_pkg;

	// ring geometry
	localparam int RING_BYTES_DEF = 8192;
	localparam int OFFSET_W       = 13;

	// header and frame length rules
	localparam int HDR_BYTES   = 4;
	localparam int MIN_LEN     = 4;
	localparam int MAX_LEN     = 1514;
	localparam int RP_BACKOFF  = 16;
	localparam int HLEN_ADJ    = HDR_BYTES + 3;
	localparam int HLEN_ADJ_MAX = 65535 + HLEN_ADJ;

	// poll outcome codes
	typedef enum logic [1:0] {
		OUTCOME_EMPTY   = 2'd0,
		OUTCOME_DROP    = 2'd1,
		OUTCOME_DELIVER = 2'd2
	} outcome_t;

	// decoded poll, held in the input stage
	typedef struct packed {
		logic                poll_en;    // dest size nonzero and receive ok
		logic                bad_len;    // masked length out of range
		logic [10:0]         copy_bytes; // clamped copy length, zero unless delivered
		logic [OFFSET_W-1:0] len_rem;    // (length + 7) mod ring size
		logic [1:0]          len_low;    // low bits of length + 7
	} poll_t;

endpackage

// File: hw/rtl/rxhr_poll_decode.sv
// decodes one poll from the header words and destination size
// depends on rxhr_pkg
module rxhr_poll_decode #(
	parameter int RING_BYTES = rxhr_pkg::RING_BYTES_DEF
) (
	input  logic [15:0]    header_status,
	input  logic [15:0]    header_length,
	input  logic [15:0]    dest_size,
	output rxhr_pkg::poll_t poll
);

	localparam int QMAX      = rxhr_pkg::HLEN_ADJ_MAX / RING_BYTES;
	localparam int RED_STEPS = $clog2(QMAX + 1);
	localparam logic [16:0] RB17 = 17'(RING_BYTES);

	logic [16:0] hlen_adj;
	logic [16:0] rem;
	logic [13:0] plen;
	logic [13:0] body;
	logic [10:0] clamped;
	logic        bad;
	logic        en;

	// reduce length + 7 modulo the ring size by shifted compare and subtract
	always_comb begin
		hlen_adj = {1'b0, header_length} + 17'(rxhr_pkg::HLEN_ADJ);
		rem = hlen_adj;
		for (int j = RED_STEPS - 1; j >= 0; j--) begin
			if (rem >= (RB17 << j)) begin
				rem = rem - (RB17 << j);
			end
		end
	end

	// length check and copy length clamp
	always_comb begin
		en   = (dest_size != 16'd0) && header_status[0];
		plen = header_length[13:0];
		bad  = (plen < 14'(rxhr_pkg::MIN_LEN)) || (plen > 14'(rxhr_pkg::MAX_LEN));
		body = plen - 14'(rxhr_pkg::MIN_LEN);
		if ({2'b00, body} > dest_size) begin
			clamped = dest_size[10:0];
		end else begin
			clamped = body[10:0];
		end
	end

	always_comb begin
		poll.poll_en    = en;
		poll.bad_len    = bad;
		poll.copy_bytes = (en && !bad) ? clamped : 11'd0;
		poll.len_rem    = rem[rxhr_pkg::OFFSET_W-1:0];
		poll.len_low    = hlen_adj[1:0];
	end

endmodule

// File: hw/rtl/rx_ring_header_reader.sv
// receive ring header reader: a poll passes the input stage, then the result register
// throughput one poll per cycle while results are taken; the offset update is one add, compare and wrap
// the length modulo ring size is reduced before the input stage, off the offset loop
// a stalled result holds the output register; the input stage still fills behind it
// arst_n clears ring offset, delivered count and both stage valid bits
module rx_ring_header_reader #(
	parameter int RING_BYTES = rxhr_pkg::RING_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        poll_valid,
	output logic        poll_ready,
	input  logic [15:0] header_status,
	input  logic [15:0] header_length,
	input  logic [15:0] dest_size,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  outcome,
	output logic [10:0] copy_length,
	output logic [13:0] data_start,
	output logic [12:0] offset_after,
	output logic [15:0] read_pointer_value,
	output logic        read_pointer_write,
	output logic [31:0] delivered_count
);

	`include "rx_ring_header_reader_macros.svh"

	localparam int OW = rxhr_pkg::OFFSET_W;
	localparam logic [OW+1:0] RB_W = (OW + 2)'(RING_BYTES);

	rxhr_pkg::poll_t poll_dec;
	rxhr_pkg::poll_t poll_s1;
	logic            valid_s1;
	logic            advance;

	logic [OW-1:0]   offset_q;
	logic [31:0]     count_q;
	logic            out_valid_q;
	logic [1:0]      outcome_q;
	logic [10:0]     copy_bytes_q;
	logic [13:0]     data_start_q;
	logic [OW-1:0]   next_off_q;
	logic [15:0]     rp_val_q;
	logic            rp_wr_q;
	logic [31:0]     count_out_q;

	logic [1:0]      low;
	logic [OW+1:0]   sum;
	logic [OW-1:0]   noff;
	logic            deliver;

	rxhr_poll_decode #(
		.RING_BYTES(RING_BYTES)
	) u_decode (
		.header_status(header_status),
		.header_length(header_length),
		.dest_size(dest_size),
		.poll(poll_dec)
	);

	// handshake: whole pipe moves when the result register is free or taken
	assign advance    = !out_valid_q || result_ready;
	assign poll_ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll_ready) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_ready && poll_valid) begin
			poll_s1 <= poll_dec;
		end
	end

	// offset advance: (offset + rem - align bits) wrapped into the ring
	always_comb begin
		low = offset_q[1:0] + poll_s1.len_low;
		sum = {2'b00, offset_q} + {2'b00, poll_s1.len_rem} - {{OW{1'b0}}, low};
		if (sum[OW+1]) begin
			noff = OW'(sum + RB_W);
		end else if (sum >= RB_W) begin
			noff = OW'(sum - RB_W);
		end else begin
			noff = sum[OW-1:0];
		end
		deliver = poll_s1.poll_en && !poll_s1.bad_len;
	end

	// ring state, updated as the transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1 && poll_s1.poll_en) begin
				offset_q <= noff;
				if (!poll_s1.bad_len) begin
					count_q <= count_q + 32'd1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			copy_bytes_q <= poll_s1.copy_bytes;
			if (poll_s1.poll_en) begin
				outcome_q  <= poll_s1.bad_len ? rxhr_pkg::OUTCOME_DROP
				                              : rxhr_pkg::OUTCOME_DELIVER;
				next_off_q <= noff;
				rp_val_q   <= {{(16 - OW){1'b0}}, noff} - 16'(rxhr_pkg::RP_BACKOFF);
				rp_wr_q    <= 1'b1;
			end else begin
				outcome_q  <= rxhr_pkg::OUTCOME_EMPTY;
				next_off_q <= offset_q;
				rp_val_q   <= 16'd0;
				rp_wr_q    <= 1'b0;
			end
			if (deliver) begin
				data_start_q <= {{(14 - OW){1'b0}}, offset_q} + 14'(rxhr_pkg::HDR_BYTES);
				count_out_q  <= count_q + 32'd1;
			end else begin
				data_start_q <= 14'd0;
				count_out_q  <= count_q;
			end
		end
	end

	assign result_valid       = out_valid_q;
	assign outcome            = outcome_q;
	assign copy_length        = copy_bytes_q;
	assign data_start         = data_start_q;
	assign offset_after       = next_off_q;
	assign read_pointer_value = rp_val_q;
	assign read_pointer_write = rp_wr_q;
	assign delivered_count    = count_out_q;

	// checks on the result register
	`RXHR_ASSERT_IMPL(a_offset_in_ring, clk, arst_n, result_valid, ({1'b0, offset_after} < 14'(RING_BYTES)))
	`RXHR_ASSERT_IMPL(a_rp_write_match, clk, arst_n, result_valid, (rp_wr_q == (outcome_q != rxhr_pkg::OUTCOME_EMPTY)))
	`RXHR_ASSERT_IMPL(a_zero_unless_deliver, clk, arst_n, result_valid && (outcome_q != rxhr_pkg::OUTCOME_DELIVER), (copy_length == 11'd0) && (data_start == 14'd0))
	`RXHR_ASSERT_NEXT(a_count_tracks_deliver, clk, arst_n, result_valid && result_ready && valid_s1 && deliver, (delivered_count == $past(count_q) + 32'd1))

endmodule
